// File: design/sparse_fiber_pointer_builder_top_macros.svh
// Assertion macros for the sparse fiber pointer builder checkers.
`ifndef SPARSE_FIBER_POINTER_BUILDER_TOP_MACROS_SVH
`define SPARSE_FIBER_POINTER_BUILDER_TOP_MACROS_SVH

// Check an implication in the same cycle.
`define SFPB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the following cycle.
`define SFPB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sfpb_pkg.sv
// Shared types and constants of the sparse fiber pointer builder.
`default_nettype none
package sfpb_pkg;
	localparam int unsigned SFPB_INDEX_BITS  = 32;
	localparam int unsigned SFPB_MAX_MODES   = 4;
	localparam int unsigned SFPB_QUEUE_DEPTH = 4;

	localparam int unsigned FIELD_W     = 32;
	localparam int unsigned VALUE_W     = 64;
	localparam int unsigned INPUT_MODES = 4;
	localparam int unsigned MODES_W     = 3;
	localparam int unsigned CFG_W       = 32;
	localparam int unsigned S_DATA_W    = 192;
	localparam int unsigned M_DATA_W    = 288;
	localparam int unsigned M_USER_W    = 2;

	typedef enum logic {
		CFG_NUM_MODES  = 1'b0,
		CFG_NUM_SLICES = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [FIELD_W-1:0] leaf_index;
		logic [VALUE_W-1:0] value_out;
		logic               new_fiber;
		logic [FIELD_W-1:0] fiber_number;
		logic [FIELD_W-1:0] fiber_start;
		logic [FIELD_W-1:0] fiber_id;
		logic [FIELD_W-1:0] fiber_slice;
		logic               fill_valid;
		logic [FIELD_W-1:0] fill_first;
		logic [FIELD_W-1:0] fill_last;
		logic               closing;
	} sfpb_result_t;

	typedef struct packed {
		sfpb_result_t nz_rec;
		logic         has_close;
		sfpb_result_t close_rec;
	} sfpb_entry_t;
endpackage
`default_nettype wire

// File: design/sfpb_front.sv
// Front end: configuration, fiber detection, counters and fill ranges.
`default_nettype none
module sfpb_front import sfpb_pkg::*; #(
	parameter int unsigned INDEX_BITS = SFPB_INDEX_BITS,
	parameter int unsigned MAX_MODES  = SFPB_MAX_MODES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  cfg_idx_t                            cfg_addr,
	input  logic [CFG_W-1:0]                    cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [INPUT_MODES-1:0][FIELD_W-1:0] in_mode,
	input  logic [VALUE_W-1:0]                  in_value,
	input  logic                                in_last,
	output logic                                push,
	output sfpb_entry_t                         entry,
	input  logic                                full
);
	localparam int unsigned IW  = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
	localparam int unsigned LIM = (MAX_MODES < INPUT_MODES) ? MAX_MODES : INPUT_MODES;
	localparam logic [MODES_W-1:0] LIM_M = MODES_W'(LIM);
	localparam logic [FIELD_W-1:0] IDX_MASK = FIELD_W'((65'(1) << IW) - 65'(1));

	logic [MODES_W-1:0]       num_modes_q;
	logic [FIELD_W-1:0]       num_slices_q;
	logic [LIM-1:0][IW-1:0]   prev_q;
	logic [FIELD_W-1:0]       nz_q;
	logic [FIELD_W-1:0]       fiber_q;
	logic [FIELD_W:0]         next_q;
	logic                     seen_q;

	logic [INPUT_MODES-1:0][FIELD_W-1:0] idx;
	logic [MODES_W-1:0] nm;
	logic [1:0]         leaf_sel;
	logic               fresh;
	logic [FIELD_W-1:0] last_e;
	logic               fill_ok;
	logic [FIELD_W:0]   next1;
	logic               close_ok;
	logic [FIELD_W-1:0] fc_next;
	logic [FIELD_W-1:0] nz_next;
	logic               accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	always_comb begin
		for (int m = 0; m < INPUT_MODES; m++) begin
			idx[m] = in_mode[m] & IDX_MASK;
		end
		if (num_modes_q < MODES_W'(2)) begin
			nm = MODES_W'(2);
		end else if (num_modes_q > LIM_M) begin
			nm = LIM_M;
		end else begin
			nm = num_modes_q;
		end
		leaf_sel = 2'(nm - MODES_W'(1));
		fresh = !seen_q;
		for (int m = 0; m < LIM - 1; m++) begin
			if ((MODES_W'(m + 1) < nm) && (idx[m][IW-1:0] != prev_q[m])) begin
				fresh = 1'b1;
			end
		end
		last_e   = (idx[0] > num_slices_q) ? num_slices_q : idx[0];
		fill_ok  = fresh && (next_q <= {1'b0, last_e});
		next1    = fill_ok ? ({1'b0, last_e} + (FIELD_W+1)'(1)) : next_q;
		close_ok = next1 <= {1'b0, num_slices_q};
		fc_next  = fiber_q + FIELD_W'(fresh);
		nz_next  = nz_q + FIELD_W'(1);
	end

	always_comb begin
		entry = '0;
		entry.nz_rec.leaf_index = idx[leaf_sel];
		entry.nz_rec.value_out  = in_value;
		entry.nz_rec.new_fiber  = fresh;
		if (fresh) begin
			entry.nz_rec.fiber_number = fiber_q;
			entry.nz_rec.fiber_start  = nz_q;
			entry.nz_rec.fiber_id     = idx[1];
			entry.nz_rec.fiber_slice  = idx[0];
		end
		if (fill_ok) begin
			entry.nz_rec.fill_valid = 1'b1;
			entry.nz_rec.fill_first = next_q[FIELD_W-1:0];
			entry.nz_rec.fill_last  = last_e;
		end
		entry.has_close              = in_last;
		entry.close_rec.fiber_number = fc_next;
		entry.close_rec.fiber_start  = nz_next;
		entry.close_rec.closing      = 1'b1;
		if (close_ok) begin
			entry.close_rec.fill_valid = 1'b1;
			entry.close_rec.fill_first = next1[FIELD_W-1:0];
			entry.close_rec.fill_last  = num_slices_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_modes_q  <= MODES_W'(3);
			num_slices_q <= FIELD_W'(1);
			prev_q       <= '0;
			nz_q         <= '0;
			fiber_q      <= '0;
			next_q       <= '0;
			seen_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_NUM_MODES: begin
						num_modes_q <= cfg_wdata[MODES_W-1:0];
					end
					CFG_NUM_SLICES: begin
						num_slices_q <= cfg_wdata[FIELD_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (in_last) begin
					prev_q  <= '0;
					nz_q    <= '0;
					fiber_q <= '0;
					next_q  <= '0;
					seen_q  <= 1'b0;
				end else begin
					for (int m = 0; m < LIM; m++) begin
						if (MODES_W'(m) < nm) begin
							prev_q[m] <= idx[m][IW-1:0];
						end
					end
					nz_q    <= nz_next;
					fiber_q <= fc_next;
					next_q  <= next1;
					seen_q  <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: design/sfpb_queue.sv
// Short queue of classified entries between front and back end.
`default_nettype none
module sfpb_queue import sfpb_pkg::*; #(
	parameter int unsigned DEPTH = SFPB_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sfpb_entry_t wr_entry,
	output logic        full,
	input  logic        pop,
	output sfpb_entry_t head,
	output logic        not_empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sfpb_entry_t   store_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10: begin
					count_q <= count_q + CW'(1);
				end
				2'b01: begin
					count_q <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: design/sfpb_back.sv
// Back end: serialize queued entries into result transfers.
`default_nettype none
module sfpb_back import sfpb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  sfpb_entry_t         head,
	input  logic                not_empty,
	output logic                pop,
	output logic                m_valid,
	input  logic                m_ready,
	output logic [M_DATA_W-1:0] m_data,
	output logic [M_USER_W-1:0] m_user,
	output logic                m_last
);
	logic         phase_q;
	logic         fire;
	sfpb_result_t rec;

	assign rec     = phase_q ? head.close_rec : head.nz_rec;
	assign m_valid = not_empty;
	assign fire    = not_empty && m_ready;
	assign pop     = fire && (phase_q || !head.has_close);
	assign m_data  = {rec.fill_last, rec.fill_first, rec.fiber_slice, rec.fiber_id,
		rec.fiber_start, rec.fiber_number, rec.value_out, rec.leaf_index};
	assign m_user  = {rec.fill_valid, rec.new_fiber};
	assign m_last  = rec.closing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (fire) begin
			phase_q <= !phase_q && head.has_close;
		end
	end
endmodule
`default_nettype wire

// File: design/sparse_fiber_pointer_builder_top.sv
// Sparse fiber pointer builder: fiber starts and slice-pointer fill ranges from sorted nonzeros.
// The block accepts one nonzero per cycle while the queue is not full; each result is
// registered in the queue before it is sent, and the last nonzero of a run yields a second,
// closing result right after its own, so a run of N nonzeros gives N+1 results. Classified nonzeros wait in a
// QUEUE_DEPTH-entry queue, so the input keeps flowing while the output is stalled until
// the queue is full. Configure num_modes and num_slices only while the block is idle.
`default_nettype none
module sparse_fiber_pointer_builder_top import sfpb_pkg::*; #(
	parameter int unsigned INDEX_BITS  = SFPB_INDEX_BITS,
	parameter int unsigned MAX_MODES   = SFPB_MAX_MODES,
	parameter int unsigned QUEUE_DEPTH = SFPB_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  cfg_idx_t            cfg_addr,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// mode0_index, mode1_index, mode2_index, mode3_index, value_bits
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// leaf_index, value_out, fiber_number, fiber_start, fiber_id, fiber_slice,
	// fill_first, fill_last
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// new_fiber, fill_valid
	output logic [M_USER_W-1:0] m_axis_tuser,
	output logic                m_axis_tlast
);
	logic [INPUT_MODES-1:0][FIELD_W-1:0] in_mode;
	logic        push;
	logic        full;
	logic        pop;
	logic        not_empty;
	sfpb_entry_t wr_entry;
	sfpb_entry_t head;

	assign in_mode = s_axis_tdata[INPUT_MODES*FIELD_W-1:0];

	sfpb_front #(
		.INDEX_BITS(INDEX_BITS),
		.MAX_MODES (MAX_MODES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_mode  (in_mode),
		.in_value (s_axis_tdata[INPUT_MODES*FIELD_W +: VALUE_W]),
		.in_last  (s_axis_tlast),
		.push     (push),
		.entry    (wr_entry),
		.full     (full)
	);

	sfpb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.not_empty(not_empty)
	);

	sfpb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.not_empty(not_empty),
		.pop      (pop),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.m_data   (m_axis_tdata),
		.m_user   (m_axis_tuser),
		.m_last   (m_axis_tlast)
	);
endmodule
`default_nettype wire

// File: design/sfpb_checker.sv
// Port-level assertions for the sparse fiber pointer builder and their bind.
`default_nettype none
`include "sparse_fiber_pointer_builder_top_macros.svh"
module sfpb_checker import sfpb_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                m_axis_tvalid,
	input wire logic                m_axis_tready,
	input wire logic [M_DATA_W-1:0] m_axis_tdata,
	input wire logic [M_USER_W-1:0] m_axis_tuser,
	input wire logic                m_axis_tlast
);
	`SFPB_ASSERT_NEXT(a_hold_stalled, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result transfer changed")
	`SFPB_ASSERT_NOW(a_closing_clean, clk, arst_n, m_axis_tvalid && m_axis_tlast, !m_axis_tuser[0] && (m_axis_tdata[95:0] == '0) && (m_axis_tdata[223:160] == '0), "closing record carries nonzero data")
	`SFPB_ASSERT_NOW(a_fill_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[287:224] == '0, "fill range set without fill_valid")
	`SFPB_ASSERT_NOW(a_fill_source, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0] || m_axis_tlast, "fill without new fiber or closing")
endmodule

bind sparse_fiber_pointer_builder_top sfpb_checker u_sfpb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
`default_nettype wire
